>>> rtl/core/b64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

	// Full groups in one output line (76 characters).
	localparam int unsigned GROUPS_PER_LINE = 19;
	// Letters in each case of the alphabet.
	localparam int unsigned ALPHA_SPAN = 26;
	// Default depth of the job queue between front and back.
	localparam int unsigned JOB_QUEUE_DEPTH = 4;

	// ASCII codes that the encoder emits besides the sextet letters.
	localparam logic [6:0] CHAR_PAD   = 7'h3D; // '='
	localparam logic [6:0] CHAR_MINUS = 7'h2D; // '-'
	localparam logic [6:0] CHAR_UNDER = 7'h5F; // '_'
	localparam logic [6:0] CHAR_CR    = 7'h0D;
	localparam logic [6:0] CHAR_LF    = 7'h0A;
	localparam logic [6:0] CHAR_UPPER_A = 7'h41;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_ZERO    = 7'h30;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_NO_LINE_BREAKS = 1'b0,
		CFG_NO_PADDING     = 1'b1
	} cfg_reg_t;

	// One unit of output work: the characters caused by one input byte.
	typedef struct packed {
		logic [23:0] word;   // sextets taken from the top, six bits at a time
		logic [2:0]  nsext;  // number of sextet characters (2 to 4)
		logic [2:0]  total;  // number of characters in all (2 to 6)
		logic        crlf;   // CR LF follows the four sextets
		logic        fin;    // this job ends the message
	} job_t;

	// Maps a six-bit value to its URL-safe alphabet character.
	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] c;
		if (7'(v) < 7'(ALPHA_SPAN)) begin
			c = CHAR_UPPER_A + 7'(v);
		end else if (7'(v) < 7'(2 * ALPHA_SPAN)) begin
			c = CHAR_LOWER_A + 7'(v) - 7'(ALPHA_SPAN);
		end else if (v < 6'd62) begin
			c = CHAR_ZERO + 7'(v) - 7'(2 * ALPHA_SPAN);
		end else if (v == 6'd62) begin
			c = CHAR_MINUS;
		end else begin
			c = CHAR_UNDER;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/b64e_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
	import b64e_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	input  wire logic [0:0] cfg_index,
	input  wire logic       cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_data,
	input  wire logic       in_final,
	output logic            push_valid,
	input  wire logic       push_ready,
	output job_t            push_job
);

	logic        no_line_breaks_q;
	logic        no_padding_q;
	logic [15:0] held_q;
	logic [1:0]  phase_q;
	logic [4:0]  groups_q;

	logic        accept;
	logic [15:0] held_n;
	logic [1:0]  phase_n;
	logic [4:0]  groups_n;
	logic [4:0]  groups_inc;
	logic        job_valid;
	job_t        job;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Group assembly, line counting and job classification for one byte.
	always_comb begin
		held_n     = held_q;
		phase_n    = phase_q;
		groups_n   = groups_q;
		groups_inc = groups_q + 5'd1;
		job_valid  = 1'b0;
		job        = '0;
		if (phase_q >= 2'd2) begin
			job_valid = 1'b1;
			job.word  = {held_q, in_data};
			job.nsext = 3'd4;
			job.crlf  = (groups_inc >= 5'(GROUPS_PER_LINE)) && !no_line_breaks_q;
			job.total = job.crlf ? 3'd6 : 3'd4;
			groups_n  = (groups_inc >= 5'(GROUPS_PER_LINE)) ? 5'd0 : groups_inc;
			held_n    = '0;
			phase_n   = 2'd0;
		end else begin
			held_n  = {held_q[7:0], in_data};
			phase_n = phase_q + 2'd1;
		end
		if (in_final) begin
			job_valid = 1'b1;
			job.fin   = 1'b1;
			if (phase_n == 2'd1) begin
				job.word  = {held_n[7:0], 16'h0000};
				job.nsext = 3'd2;
				job.total = no_padding_q ? 3'd2 : 3'd4;
			end else if (phase_n == 2'd2) begin
				job.word  = {held_n, 8'h00};
				job.nsext = 3'd3;
				job.total = no_padding_q ? 3'd3 : 3'd4;
			end
			held_n   = '0;
			phase_n  = 2'd0;
			groups_n = '0;
		end
	end

	assign push_valid = accept && job_valid;
	assign push_job   = job;

	// Message state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			phase_q  <= '0;
			groups_q <= '0;
		end else if (accept) begin
			held_q   <= held_n;
			phase_q  <= phase_n;
			groups_q <= groups_n;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_line_breaks_q <= 1'b0;
			no_padding_q     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_NO_LINE_BREAKS: no_line_breaks_q <= cfg_data;
				CFG_NO_PADDING:     no_padding_q     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/b64e_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue
	import b64e_pkg::*;
#(
	parameter int unsigned DEPTH = JOB_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  job_t      push_job,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output job_t      pop_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Slot storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/b64e_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
	import b64e_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  job_t      pop_job,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [6:0] out_char,
	output logic      out_run_last,
	output logic      out_msg_end
);

	logic        active_q;
	logic [23:0] word_q;
	logic [2:0]  pos_q;
	logic [2:0]  nsext_q;
	logic [2:0]  total_q;
	logic        crlf_q;
	logic        fin_q;

	logic        out_valid_q;
	logic [6:0]  out_char_q;
	logic        out_run_last_q;
	logic        out_msg_end_q;

	logic        out_free;
	logic        emit;
	logic        last_char;
	logic [6:0]  next_char;

	assign out_free  = !out_valid_q || out_ready;
	assign emit      = active_q && out_free;
	assign last_char = (pos_q == total_q - 3'd1);
	assign pop_ready = !active_q || (emit && last_char);

	// Character at the current position of the job.
	always_comb begin
		if (pos_q < nsext_q) begin
			next_char = sextet_char(word_q[23:18]);
		end else if (crlf_q) begin
			next_char = (pos_q == 3'd4) ? CHAR_CR : CHAR_LF;
		end else begin
			next_char = CHAR_PAD;
		end
	end

	// Job control: load from the queue, step one character per emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop_valid && pop_ready) begin
			active_q <= 1'b1;
		end else if (emit && last_char) begin
			active_q <= 1'b0;
		end
	end

	// Job payload.
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			word_q  <= pop_job.word;
			nsext_q <= pop_job.nsext;
			total_q <= pop_job.total;
			crlf_q  <= pop_job.crlf;
			fin_q   <= pop_job.fin;
			pos_q   <= '0;
		end else if (emit) begin
			word_q <= {word_q[17:0], 6'b0};
			pos_q  <= pos_q + 3'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q     <= next_char;
			out_run_last_q <= last_char;
			out_msg_end_q  <= last_char && fin_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign out_run_last = out_run_last_q;
	assign out_msg_end  = out_msg_end_q;

endmodule

`default_nettype wire

>>> rtl/core/base64_url_encoder_with_line_breaks.sv
// URL-safe base64 encoder with optional CR LF after every 76 characters.
// Input stream s_axis: one message byte per transaction, tlast on the final
// byte. Output stream m_axis: one ASCII character per transaction, tlast on
// the last character caused by an input byte, tuser on the last character of
// the message. A byte that completes no group and is not final gives nothing.
// Configuration: cfg_index 0 is no_line_breaks, 1 is no_padding; cfg_ready is
// always high and writes are meant for times when the encoder is idle.
// A byte's job passes through a queue slot and the back-end job registers
// to the output register. The back end emits one character per cycle while
// the receiver takes them, so a three-byte group gives four characters, or
// six when it ends a line; the front end takes a byte per cycle while the job
// queue has room. Sustained, the one-character-per-cycle output sets the pace;
// a one-byte message with padding gives four characters.
// Reset clears the message state, the registers and the queue; no clearing
// pass follows. When the receiver stalls, the output register holds its
// character, the queue fills, and s_axis_tready falls once it is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_url_encoder_with_line_breaks
	import b64e_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [0:0] cfg_index,
	input  wire logic       cfg_data,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  wire logic       s_axis_tlast,  // final_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [6:0] out_char, [7] zero
	output logic            m_axis_tlast,  // run_last
	output logic            m_axis_tuser   // [0] message_end
);

	logic       push_valid;
	logic       push_ready;
	job_t       push_job;
	logic       pop_valid;
	logic       pop_ready;
	job_t       pop_job;
	logic [6:0] out_char;

	assign cfg_ready = 1'b1;

	// Front end: byte intake and group classification.
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_final   (s_axis_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Job queue between the two ends.
	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Back end: character generation.
	b64e_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_job      (pop_job),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_char     (out_char),
		.out_run_last (m_axis_tlast),
		.out_msg_end  (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

>>> rtl/core/b64e_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_checker
	import b64e_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast,
	input wire logic       m_axis_tuser
);

	// A stalled character stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// The end of a message is always the end of a byte's characters.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("message end without run end");

	// Characters are seven-bit ASCII.
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[7])
		else $error("output character above 7 bits");

	// CR is always followed by LF within the same byte's characters.
	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[6:0] == CHAR_CR) |-> !m_axis_tlast)
		else $error("CR ends a run");

	// After a CR is taken, the next character shown is LF.
	a_cr_lf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && (m_axis_tdata[6:0] == CHAR_CR) |=>
			!m_axis_tvalid || (m_axis_tdata[6:0] == CHAR_LF))
		else $error("CR not followed by LF");

endmodule

bind base64_url_encoder_with_line_breaks b64e_checker u_b64e_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
